// ===== sv/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, reset value and controller/datapath interface types for the
// modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_W  = 32;
    localparam int EXP_W  = 63;
    localparam int BASE_W = 63;
    localparam int CNT_W  = $clog2(BASE_W);

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

    // Product selection for the shared modular multiplier
    typedef enum logic {
        MM_SEL_MUL = 1'b0,   // result * square
        MM_SEL_SQR = 1'b1    // square * square
    } mm_sel_t;

    typedef struct packed {
        logic    load;        // capture input transfer
        logic    red_step;    // one bit of base reduction
        logic    mm_start;    // load multiplier operands
        mm_sel_t mm_sel;
        logic    mm_step;     // one bit of shift-and-add
        logic    commit_mul;  // result <= product
        logic    commit_sqr;  // square <= product
        logic    exp_shift;   // advance exponent by one bit
        logic    out_load;    // load output register
    } dp_cmd_t;

    typedef struct packed {
        logic mod_small;      // modulus below two
        logic zero_case;      // base and effective exponent both zero
        logic exp_zero;
        logic exp_lsb;
        logic exp_next_zero;  // exponent shifted right is zero
        logic mm_done;        // multiplier operand exhausted
    } dp_sts_t;

endpackage

// ===== sv/mexp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: modulus register, bit-serial base reduction, shift-and-add
// modular multiplier, exponent shifter and output data register.
// ----------------------------------------------------------------------------
module mexp_dp
    import mexp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [MOD_W-1:0]  cfg_wr_data,
    input  logic              s_cmd,
    input  logic [BASE_W-1:0] s_base,
    input  logic [EXP_W-1:0]  s_exponent,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    output logic [MOD_W-1:0]  m_power_result
);

    logic [MOD_W-1:0]  mod_reg;
    logic [BASE_W-1:0] base_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [MOD_W-1:0]  res_reg;
    logic [MOD_W-1:0]  sq_reg;     // also the running remainder during reduction
    logic [MOD_W-1:0]  acc_reg;
    logic [MOD_W-1:0]  x_reg;
    logic [MOD_W-1:0]  y_reg;
    logic              zero_reg;
    logic [MOD_W-1:0]  out_reg;

    logic [EXP_W-1:0]  exp_eff;
    logic [MOD_W:0]    rem_shift;
    logic [MOD_W-1:0]  rem_next;
    logic [MOD_W-1:0]  acc_next;
    logic [MOD_W-1:0]  x_next;

    // (a + b) mod m for a, b < m without growing past the modulus width
    function automatic logic [MOD_W-1:0] add_mod(
        input logic [MOD_W-1:0] a,
        input logic [MOD_W-1:0] b,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W-1:0] room;
        room = m - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    always_comb begin
        exp_eff   = s_cmd ? {{(EXP_W-MOD_W){1'b0}}, mod_reg - MOD_W'(2)} : s_exponent;
        rem_shift = {sq_reg, base_reg[BASE_W-1]};
        rem_next  = (rem_shift >= {1'b0, mod_reg}) ?
                    MOD_W'(rem_shift - {1'b0, mod_reg}) : MOD_W'(rem_shift);
        acc_next  = y_reg[0] ? add_mod(acc_reg, x_reg, mod_reg) : acc_reg;
        x_next    = add_mod(x_reg, x_reg, mod_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= MOD_RESET;
        end else if (cfg_wr_en) begin
            mod_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= s_base;
            exp_reg  <= exp_eff;
            zero_reg <= (s_base == '0) && (exp_eff == '0);
            sq_reg   <= '0;
            res_reg  <= MOD_W'(1);
        end else begin
            if (cmd.red_step) begin
                sq_reg   <= rem_next;
                base_reg <= base_reg << 1;
            end
            if (cmd.commit_mul) begin
                res_reg <= acc_reg;
            end
            if (cmd.commit_sqr) begin
                sq_reg <= acc_reg;
            end
            if (cmd.exp_shift) begin
                exp_reg <= exp_reg >> 1;
            end
        end

        if (cmd.mm_start) begin
            acc_reg <= '0;
            x_reg   <= sq_reg;
            y_reg   <= (cmd.mm_sel == MM_SEL_MUL) ? res_reg : sq_reg;
        end else if (cmd.mm_step) begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_reg >> 1;
        end

        if (cmd.out_load) begin
            out_reg <= (zero_reg || (mod_reg < MOD_W'(2))) ? '0 : res_reg;
        end
    end

    always_comb begin
        sts.mod_small     = (mod_reg < MOD_W'(2));
        sts.zero_case     = zero_reg;
        sts.exp_zero      = (exp_reg == '0);
        sts.exp_lsb       = exp_reg[0];
        sts.exp_next_zero = (exp_reg[EXP_W-1:1] == '0);
        sts.mm_done       = (y_reg == '0);
    end

    assign m_power_result = out_reg;

endmodule

// ===== sv/mexp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences base reduction, the square-and-multiply loop and the
// output handshake.
// ----------------------------------------------------------------------------
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_CHK,
        S_MUL,
        S_SQR,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_RED;
                end
            end
            S_RED: begin
                cmd.red_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(BASE_W - 1)) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (sts.mod_small || sts.zero_case || sts.exp_zero) begin
                    state_next = S_OUT;
                end else if (sts.exp_lsb) begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = MM_SEL_MUL;
                    state_next   = S_MUL;
                end else begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = MM_SEL_SQR;
                    state_next   = S_SQR;
                end
            end
            S_MUL: begin
                if (!sts.mm_done) begin
                    cmd.mm_step = 1'b1;
                end else begin
                    cmd.commit_mul = 1'b1;
                    if (sts.exp_next_zero) begin
                        // last set bit: the final square is not needed
                        cmd.exp_shift = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        cmd.mm_start = 1'b1;
                        cmd.mm_sel   = MM_SEL_SQR;
                        state_next   = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (!sts.mm_done) begin
                    cmd.mm_step = 1'b1;
                end else begin
                    cmd.commit_sqr = 1'b1;
                    cmd.exp_shift  = 1'b1;
                    state_next     = S_CHK;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== sv/modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base^exponent mod modulus by right-to-left square and multiply;
// inverse operation uses exponent modulus-2.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_cmd, s_base, s_exponent
//  m_        out        m_valid / m_ready      m_power_result
//  cfg_      in         cfg_wr_en              cfg_wr_data (modulus)
//
//  One item at a time. Base reduction produces one remainder bit per cycle,
//  then each exponent bit below its top set bit costs a square and each set
//  bit a multiply on the shared shift-and-add unit, with a check step before
//  each bit.
//  Reset is synchronous and restores the modulus to 1000000007.
//  A finished result waits in the output register; a new item is taken
//  meanwhile and stalls only at its own output load.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [MOD_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [BASE_W-1:0] s_base,
    input  logic [EXP_W-1:0]  s_exponent,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [MOD_W-1:0]  m_power_result
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    mexp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_cmd          (s_cmd),
        .s_base         (s_base),
        .s_exponent     (s_exponent),
        .cmd            (dp_cmd),
        .sts            (dp_sts),
        .m_power_result (m_power_result)
    );

endmodule

// ===== tb/tb_modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the modular exponentiation core. Directed items
// cover zero bases and exponents, a base that is a multiple of the modulus,
// the inverse operation, the smallest and largest moduli and out-of-range
// moduli. Random items follow under several moduli, with bursty input and a
// stalling result channel. A local square-and-multiply predictor computes
// each expected power, and every result transfer is compared in order.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_core;
    import mexp_pkg::*;

    localparam logic CMD_POWER       = 1'b0;
    localparam logic CMD_INVERSE     = 1'b1;
    localparam int   CYCLE_LIMIT     = 4_000_000;
    localparam int   HOLD_OFF_CYCLES = 3000;
    localparam int   DRAIN_CYCLES    = 200;
    localparam int   RANDOM_PHASES   = 7;
    localparam int   ITEMS_PER_PHASE = 16;

    localparam logic [BASE_W-1:0] ALL_ONES = '1;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [MOD_W-1:0]  cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic [BASE_W-1:0] s_base;
    logic [EXP_W-1:0]  s_exponent;
    logic              m_valid;
    logic              m_ready;
    logic [MOD_W-1:0]  m_power_result;

    logic [MOD_W-1:0]  modulus_now;
    // expected powers in transfer order, indexed by the low bits of the counts
    logic [MOD_W-1:0]  pending_powers[0:15];
    int                sent_count     = 0;
    int                checked_count  = 0;
    int                fail_count     = 0;
    int                cycle_count    = 0;
    int                burst_left     = 0;
    bit                sender_no_gaps = 1'b0;
    int                hold_off_asked = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    modular_exponentiation_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_base         (s_base),
        .s_exponent     (s_exponent),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_power_result (m_power_result)
    );

    // Right-to-left square and multiply on exact 64-bit products
    function automatic logic [MOD_W-1:0] predict_power(input logic op,
                                                       input logic [BASE_W-1:0] b,
                                                       input logic [EXP_W-1:0] e,
                                                       input logic [MOD_W-1:0] m);
        logic [63:0]      acc;
        logic [63:0]      sq;
        logic [EXP_W-1:0] k;
        if (m < MOD_W'(2)) return '0;
        k = (op == CMD_INVERSE) ? EXP_W'(m - MOD_W'(2)) : e;
        // zero test uses the base as given, not the reduced one
        if (b == '0 && k == '0) return '0;
        acc = 64'd1;
        sq  = b % m;
        while (k != '0) begin
            if (k[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            k  = k >> 1;
        end
        return acc[MOD_W-1:0];
    endfunction

    function automatic logic [BASE_W-1:0] random_operand(input int n);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return BASE_W'(raw & ((64'd1 << n) - 64'd1));
    endfunction

    task automatic send_item(input logic op, input logic [BASE_W-1:0] b,
                             input logic [EXP_W-1:0] e);
        int gap;
        if (!sender_no_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 3000)
                                                   : $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left--;
        end
        s_valid    <= 1'b1;
        s_cmd      <= op;
        s_base     <= b;
        s_exponent <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_powers[4'(sent_count)] = predict_power(op, b, e, modulus_now);
        sent_count++;
    endtask

    // Drop valid in the step of the last transfer, before time moves on
    task automatic end_sending();
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sent_count != checked_count) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [MOD_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        modulus_now = value;
    endtask

    task automatic test_reset_modulus();
        send_item(CMD_POWER, '0, '0);
        send_item(CMD_POWER, 63'd5, '0);
        send_item(CMD_POWER, '0, 63'd5);
        send_item(CMD_POWER, BASE_W'(MOD_RESET), '0);
        send_item(CMD_POWER, BASE_W'(MOD_RESET), 63'd3);
        send_item(CMD_POWER, ALL_ONES, ALL_ONES);
        send_item(CMD_POWER, 63'd123456789, 63'd1);
        send_item(CMD_INVERSE, 63'd2, ALL_ONES);
        send_item(CMD_INVERSE, '0, 63'd77);
        send_item(CMD_INVERSE, BASE_W'(MOD_RESET) * 2, '0);
        end_sending();
    endtask

    task automatic test_modulus_extremes();
        write_modulus(MOD_W'(2));
        send_item(CMD_INVERSE, '0, ALL_ONES);
        send_item(CMD_INVERSE, 63'd3, '0);
        send_item(CMD_POWER, ALL_ONES, 63'd5);
        send_item(CMD_POWER, 63'd2, 63'd1);
        end_sending();
        write_modulus('1);
        send_item(CMD_POWER, ALL_ONES, ALL_ONES);
        send_item(CMD_INVERSE, 63'd2, 63'd9);
        send_item(CMD_INVERSE, 63'd3, '0);
        send_item(CMD_POWER, 63'hFFFF_FFFE, 63'd2);
        end_sending();
    endtask

    task automatic test_out_of_range_modulus();
        write_modulus('0);
        send_item(CMD_POWER, 63'd5, 63'd3);
        send_item(CMD_INVERSE, 63'd7, '0);
        end_sending();
        write_modulus(MOD_W'(1));
        send_item(CMD_POWER, '0, '0);
        send_item(CMD_POWER, 63'd9, 63'd9);
        end_sending();
    endtask

    // Long result stall with input offered back to back: the core must block
    task automatic test_input_backpressure();
        write_modulus(MOD_W'(1000003));
        hold_off_asked++;
        sender_no_gaps = 1'b1;
        repeat (6) send_item(CMD_POWER, random_operand(40), random_operand(8));
        end_sending();
        sender_no_gaps = 1'b0;
    endtask

    task automatic test_random_items();
        logic [MOD_W-1:0] m;
        logic             op;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       m = MOD_W'(32'd4294967291);
                1:       m = MOD_W'($urandom_range(3, 255));
                2:       m = MOD_W'(998244353);
                3:       m = $urandom;
                4:       m = MOD_W'(65521);
                5:       m = MOD_RESET;
                default: m = MOD_W'($urandom_range(2, 65535));
            endcase
            write_modulus(m);
            sender_no_gaps = (phase == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                op = ($urandom_range(0, 1) == 1) ? CMD_INVERSE : CMD_POWER;
                // mostly short exponents; a few full width
                send_item(op,
                          random_operand(($urandom_range(0, 3) == 0) ? BASE_W
                                                                     : $urandom_range(0, 40)),
                          random_operand(($urandom_range(0, 5) == 0) ? EXP_W
                                                                     : $urandom_range(0, 20)));
            end
            end_sending();
        end
        sender_no_gaps = 1'b0;
    endtask

    initial begin : result_sink
        int mode;
        int window;
        int hold_off_served;
        mode            = 0;
        window          = 0;
        hold_off_served = 0;
        m_ready         = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_asked != hold_off_served) begin
                hold_off_served++;
                m_ready <= 1'b0;
                for (int i = 0; i < HOLD_OFF_CYCLES; i++) @(posedge aclk);
            end
            if (window == 0) begin
                mode   = $urandom_range(0, 2);
                window = $urandom_range(64, 512);
            end
            window--;
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        logic [MOD_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (checked_count == sent_count) begin
                $display("%0t: power_result expected none, actual %0d", $time,
                         m_power_result);
                fail_count++;
            end else begin
                want = pending_powers[4'(checked_count)];
                checked_count++;
                if (m_power_result !== want) begin
                    $display("%0t: power_result expected %0d, actual %0d", $time,
                             want, m_power_result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : run
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_cmd       = CMD_POWER;
        s_base      = '0;
        s_exponent  = '0;
        modulus_now = MOD_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_modulus();
        test_modulus_extremes();
        test_out_of_range_modulus();
        test_input_backpressure();
        test_random_items();
        while (sent_count != checked_count) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
